[design/nrs_pkg.sv]
// Shared types and constants for the NACK receive scoreboard.
// Used by nrs_ctrl, nrs_dp and nack_receive_scoreboard; depends on nothing.
package nrs_pkg;

	// Transfer sizing
	localparam int MAX_PACKETS   = 4096;
	localparam int PAYLOAD_BYTES = 1024;

	// Field widths
	localparam int SEQ_IN_W  = 16;                      // arrival sequence field
	localparam int SEQ_W     = $clog2(MAX_PACKETS);     // in-range sequence index
	localparam int CNT_W     = 13;                      // packet count / totals
	localparam int LEN_W     = 11;                      // write length
	localparam int OFFS_W    = 22;                      // write offset
	localparam int CFG_W     = 13;                      // widest config register
	localparam int CFG_IDX_W = 1;

	// Bitmap organization: rows of 32 bits
	localparam int ROW_W      = 32;
	localparam int ROW_BIT_W  = $clog2(ROW_W);
	localparam int ROWS       = MAX_PACKETS / ROW_W;
	localparam int ROW_ADDR_W = $clog2(ROWS);

	// Ratio thresholds as integer numerators over a denominator of ten
	localparam int RATIO_DEN = 10;
	localparam int ARM_NUM   = 8;
	localparam int EARLY_NUM = 7;
	localparam int LOOK_NUM  = 3;

	// x / 10 as (x * 6554) >> 16, exact for x below 12288 (3 * MAX_PACKETS)
	localparam int DIV10_MUL = 6554;
	localparam int DIV10_SH  = 16;

	// Config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_BYTES   = 1'd1;

	// Op codes
	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_POLL    = 1'b1;

	// Bitmap read address select
	localparam logic [1:0] RD_IN     = 2'd0;
	localparam logic [1:0] RD_FLOOR  = 2'd1;
	localparam logic [1:0] RD_CURSOR = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic       load;        // capture request, start row read
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       arr_commit;  // finish arrival, load output
		logic       poll_start;  // latch lookahead bound, clear NACK
		logic       floor_step;  // consume one floor row
		logic       scan_step;   // consume one scan row (or give up)
		logic       emit_poll;   // load poll result into output
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic in_op;        // op of the request on the input port
		logic poll_active;  // armed and not all received
		logic floor_done;   // floor at or beyond its bound
		logic cursor_out;   // cursor at or beyond packet count
		logic fl_more;      // floor row fully set, keep walking
		logic sc_more;      // scan row had no gap, keep walking
	} dp_status_t;

endpackage

[design/nrs_ctrl.sv]
// Controller state machine for the NACK receive scoreboard.
// Depends on nrs_pkg; drives nrs_dp through ctrl_cmd_t and reads dp_status_t.
module nrs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output nrs_pkg::ctrl_cmd_t cmd,
	input  nrs_pkg::dp_status_t sts
);
	import nrs_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ARR    = 3'd1;
	localparam logic [2:0] ST_FL_CHK = 3'd2;
	localparam logic [2:0] ST_FL_ROW = 3'd3;
	localparam logic [2:0] ST_SC_CHK = 3'd4;
	localparam logic [2:0] ST_SC_ROW = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0] state_q, state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load       = 1'b1;
					cmd.rd_en      = 1'b1;
					cmd.rd_sel     = RD_IN;
					cmd.poll_start = (sts.in_op == OP_POLL);
					if (sts.in_op == OP_ARRIVAL) begin
						state_nxt = ST_ARR;
					end else if (sts.poll_active) begin
						state_nxt = ST_FL_CHK;
					end else begin
						state_nxt = ST_EMIT;
					end
				end
			end
			ST_ARR: begin
				if (out_free) begin
					cmd.arr_commit = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end
			ST_FL_CHK: begin
				if (sts.floor_done) begin
					state_nxt = ST_SC_CHK;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_FLOOR;
					state_nxt  = ST_FL_ROW;
				end
			end
			ST_FL_ROW: begin
				cmd.floor_step = 1'b1;
				state_nxt      = sts.fl_more ? ST_FL_CHK : ST_SC_CHK;
			end
			ST_SC_CHK: begin
				if (sts.cursor_out) begin
					cmd.scan_step = 1'b1;
					state_nxt     = ST_EMIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_CURSOR;
					state_nxt  = ST_SC_ROW;
				end
			end
			ST_SC_ROW: begin
				cmd.scan_step = 1'b1;
				state_nxt     = sts.sc_more ? ST_SC_CHK : ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit_poll = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.arr_commit || cmd.emit_poll) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/nrs_dp.sv]
// Datapath for the NACK receive scoreboard: bitmap memory, counters,
// floor/cursor walkers, config registers and output registers. Depends on nrs_pkg.
module nrs_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nrs_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            op,
	input  logic [nrs_pkg::SEQ_IN_W-1:0]    seq_num,
	input  nrs_pkg::ctrl_cmd_t              cmd,
	output nrs_pkg::dp_status_t             sts,
	output logic                            accepted,
	output logic [nrs_pkg::OFFS_W-1:0]      write_offset,
	output logic [nrs_pkg::LEN_W-1:0]       write_length,
	output logic                            nack_valid,
	output logic [nrs_pkg::SEQ_W-1:0]       nack_seq,
	output logic                            all_received,
	output logic                            polling_armed
);
	import nrs_pkg::*;

	// First set bit of a row, lowest index first
	function automatic logic [ROW_BIT_W:0] first_set(input logic [ROW_W-1:0] v);
		logic [ROW_BIT_W:0] r;
		r = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, ROW_BIT_W'(i)};
			end
		end
		return r;
	endfunction

	// Config registers
	logic [CNT_W-1:0] pkt_count_q;
	logic [LEN_W-1:0] last_bytes_q;

	// Scoreboard state
	logic [CNT_W-1:0] total_q;
	logic [SEQ_W-1:0] highest_q;
	logic [CNT_W-1:0] floor_q;
	logic [CNT_W-1:0] cursor_q;
	logic             armed_q;
	logic [CNT_W-1:0] bound_q;
	logic             nack_found_q;
	logic [SEQ_W-1:0] nack_seq_q;
	logic [SEQ_IN_W-1:0] seq_q;

	// Bitmap memory with per-row valid flags
	logic [ROW_W-1:0]      map_mem [ROWS];
	logic [ROWS-1:0]       row_vld_q;
	logic [ROW_W-1:0]      rd_data_q;
	logic                  rd_vld_q;
	logic [ROW_ADDR_W-1:0] rd_addr;
	logic [ROW_ADDR_W-1:0] wr_addr;
	logic [ROW_W-1:0]      wr_data;
	logic                  wr_en;
	logic [ROW_W-1:0]      row;

	// Output registers
	logic             accepted_q;
	logic [OFFS_W-1:0] offset_q;
	logic [LEN_W-1:0] length_q;
	logic             nack_valid_q;
	logic [SEQ_W-1:0] nack_seq_out_q;
	logic             all_rx_q;
	logic             armed_out_q;

	// Effective packet count
	logic [CNT_W-1:0] n;
	assign n = (pkt_count_q > CNT_W'(MAX_PACKETS)) ? CNT_W'(MAX_PACKETS) : pkt_count_q;

	// Arrival decode
	logic             in_rng, acc;
	logic [CNT_W-1:0] total_new;
	logic [SEQ_W-1:0] highest_new;
	logic             all_new, armed_new, last_hit;
	logic [15:0]      hi10, n8;

	always_comb begin
		in_rng      = seq_q < SEQ_IN_W'(n);
		acc         = in_rng && !row[seq_q[ROW_BIT_W-1:0]];
		total_new   = acc ? total_q + CNT_W'(1) : total_q;
		highest_new = (acc && (seq_q[SEQ_W-1:0] > highest_q)) ? seq_q[SEQ_W-1:0] : highest_q;
		all_new     = (total_new == n);
		hi10        = 16'(highest_new) * 16'(RATIO_DEN);
		n8          = 16'(n) * 16'(ARM_NUM);
		armed_new   = armed_q || (!all_new && (hi10 >= n8));
		last_hit    = (SEQ_IN_W'(n) - SEQ_IN_W'(1)) == seq_q;
	end

	// Lookahead bound for the floor: min(n, limit + 1)
	logic [15:0]              hi10_cur, n7;
	logic [13:0]              n3;
	logic [27:0]              n3_prod;
	logic [LEN_W-1:0]         look;
	logic [CNT_W-1:0]         limit_p1, bound_nxt;

	always_comb begin
		hi10_cur  = 16'(highest_q) * 16'(RATIO_DEN);
		n7        = 16'(n) * 16'(EARLY_NUM);
		n3        = 14'(n) * 14'(LOOK_NUM);
		n3_prod   = 28'(n3) * 28'(DIV10_MUL);
		look      = LEN_W'(n3_prod >> DIV10_SH);
		limit_p1  = CNT_W'(highest_q) + CNT_W'(1);
		if (hi10_cur > n7) begin
			limit_p1 = limit_p1 + CNT_W'(look);
		end
		bound_nxt = (limit_p1 < n) ? limit_p1 : n;
	end

	// Floor walker: first clear bit at or above the floor in its row
	logic [ROW_W-1:0]     fl_gap;
	logic [ROW_BIT_W:0]   fl_hit;
	logic [CNT_W-1:0]     fl_t, fl_end, floor_nxt;
	logic                 fl_more;

	always_comb begin
		fl_gap  = ~row & ({ROW_W{1'b1}} << floor_q[ROW_BIT_W-1:0]);
		fl_hit  = first_set(fl_gap);
		fl_t    = {floor_q[CNT_W-1:ROW_BIT_W], fl_hit[ROW_BIT_W-1:0]};
		fl_end  = {floor_q[CNT_W-1:ROW_BIT_W], ROW_BIT_W'(0)} + CNT_W'(ROW_W);
		fl_more = !fl_hit[ROW_BIT_W] && (fl_end < bound_q);
		if (fl_more) begin
			floor_nxt = fl_end;
		end else if (fl_hit[ROW_BIT_W]) begin
			floor_nxt = (fl_t < bound_q) ? fl_t : bound_q;
		end else begin
			floor_nxt = bound_q;
		end
	end

	// Scan walker: first clear bit at or above the cursor, below n
	logic [ROW_W-1:0]   sc_gap;
	logic [ROW_BIT_W:0] sc_hit;
	logic [CNT_W-1:0]   sc_t, sc_end;
	logic               sc_more, sc_found;

	always_comb begin
		sc_gap   = ~row & ({ROW_W{1'b1}} << cursor_q[ROW_BIT_W-1:0]);
		sc_hit   = first_set(sc_gap);
		sc_t     = {cursor_q[CNT_W-1:ROW_BIT_W], sc_hit[ROW_BIT_W-1:0]};
		sc_end   = {cursor_q[CNT_W-1:ROW_BIT_W], ROW_BIT_W'(0)} + CNT_W'(ROW_W);
		sc_found = sc_hit[ROW_BIT_W] && (sc_t < n);
		sc_more  = !sc_hit[ROW_BIT_W] && (sc_end < n);
	end

	// Status to controller
	always_comb begin
		sts.in_op       = op;
		sts.poll_active = armed_q && (total_q != n);
		sts.floor_done  = (floor_q >= bound_q);
		sts.cursor_out  = (cursor_q >= n);
		sts.fl_more     = fl_more;
		sts.sc_more     = sc_more;
	end

	// Bitmap addressing
	always_comb begin
		unique case (cmd.rd_sel)
			RD_IN:     rd_addr = seq_num[SEQ_W-1:ROW_BIT_W];
			RD_FLOOR:  rd_addr = floor_q[SEQ_W-1:ROW_BIT_W];
			RD_CURSOR: rd_addr = cursor_q[SEQ_W-1:ROW_BIT_W];
			default:   rd_addr = seq_num[SEQ_W-1:ROW_BIT_W];
		endcase
		row     = rd_vld_q ? rd_data_q : '0;
		wr_en   = cmd.arr_commit && acc;
		wr_addr = seq_q[SEQ_W-1:ROW_BIT_W];
		wr_data = row | (ROW_W'(1) << seq_q[ROW_BIT_W-1:0]);
	end

	// Bitmap storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= map_mem[rd_addr];
		end
	end

	// Row valid flags and read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// Config registers and scoreboard state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_count_q  <= CNT_W'(1);
			last_bytes_q <= LEN_W'(PAYLOAD_BYTES);
			total_q      <= '0;
			highest_q    <= '0;
			floor_q      <= '0;
			cursor_q     <= '0;
			armed_q      <= 1'b0;
			bound_q      <= '0;
			nack_found_q <= 1'b0;
			nack_seq_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PACKET_COUNT: pkt_count_q  <= cfg_data;
					REG_LAST_BYTES:   last_bytes_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.arr_commit) begin
				total_q   <= total_new;
				highest_q <= highest_new;
				armed_q   <= armed_new;
			end
			if (cmd.poll_start) begin
				bound_q      <= bound_nxt;
				nack_found_q <= 1'b0;
				nack_seq_q   <= '0;
			end
			if (cmd.floor_step) begin
				floor_q <= floor_nxt;
			end
			if (cmd.scan_step) begin
				if (sts.cursor_out) begin
					cursor_q <= floor_q;
				end else if (sc_found) begin
					nack_found_q <= 1'b1;
					nack_seq_q   <= sc_t[SEQ_W-1:0];
					cursor_q     <= (sc_t == n - CNT_W'(1)) ? floor_q : sc_t + CNT_W'(1);
				end else if (sc_more) begin
					cursor_q <= sc_end;
				end else begin
					cursor_q <= floor_q;
				end
			end
		end
	end

	// Request capture and output registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q <= seq_num;
		end
		if (cmd.arr_commit) begin
			accepted_q     <= acc;
			offset_q       <= acc ? OFFS_W'(32'(seq_q) * 32'(PAYLOAD_BYTES)) : '0;
			length_q       <= acc ? (last_hit ? last_bytes_q : LEN_W'(PAYLOAD_BYTES)) : '0;
			nack_valid_q   <= 1'b0;
			nack_seq_out_q <= '0;
			all_rx_q       <= all_new;
			armed_out_q    <= armed_new;
		end else if (cmd.emit_poll) begin
			accepted_q     <= 1'b0;
			offset_q       <= '0;
			length_q       <= '0;
			nack_valid_q   <= nack_found_q;
			nack_seq_out_q <= nack_seq_q;
			all_rx_q       <= (total_q == n);
			armed_out_q    <= armed_q;
		end
	end

	assign accepted      = accepted_q;
	assign write_offset  = offset_q;
	assign write_length  = length_q;
	assign nack_valid    = nack_valid_q;
	assign nack_seq      = nack_seq_out_q;
	assign all_received  = all_rx_q;
	assign polling_armed = armed_out_q;

endmodule

[design/nack_receive_scoreboard.sv]
// Arrival: the row is read, then the bit is set and written back as the result is loaded.
// Poll: when not armed or all received, the result is loaded with no bitmap walk; otherwise
// the floor advance and then the gap scan each walk bitmap rows of 32, reading one row per step.
// One request in flight; the next is taken while the last result waits to be taken.
// Reset clears the scoreboard state at once: per-row valid flags make the bitmap read as empty.
module nack_receive_scoreboard (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nrs_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [nrs_pkg::SEQ_IN_W-1:0]  seq_num,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          accepted,
	output logic [nrs_pkg::OFFS_W-1:0]    write_offset,
	output logic [nrs_pkg::LEN_W-1:0]     write_length,
	output logic                          nack_valid,
	output logic [nrs_pkg::SEQ_W-1:0]     nack_seq,
	output logic                          all_received,
	output logic                          polling_armed
);
	import nrs_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	// Sequencer
	nrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Bitmap, counters and result registers
	nrs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.seq_num       (seq_num),
		.cmd           (cmd),
		.sts           (sts),
		.accepted      (accepted),
		.write_offset  (write_offset),
		.write_length  (write_length),
		.nack_valid    (nack_valid),
		.nack_seq      (nack_seq),
		.all_received  (all_received),
		.polling_armed (polling_armed)
	);

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for nack_receive_scoreboard: directed and random request
// streams, each result checked in order against a local model of the bitmap.
// Depends on nrs_pkg and the nack_receive_scoreboard RTL.
module tb_top;
	import nrs_pkg::*;

	// Upper bound on run length, well past the slowest legal run
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int END_CYCLES  = 64;

	typedef struct packed {
		logic              accepted;
		logic [OFFS_W-1:0] write_offset;
		logic [LEN_W-1:0]  write_length;
		logic              nack_valid;
		logic [SEQ_W-1:0]  nack_seq;
		logic              all_received;
		logic              polling_armed;
	} result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 op = OP_ARRIVAL;
	logic [SEQ_IN_W-1:0]  seq_num = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 accepted;
	logic [OFFS_W-1:0]    write_offset;
	logic [LEN_W-1:0]     write_length;
	logic                 nack_valid;
	logic [SEQ_W-1:0]     nack_seq;
	logic                 all_received;
	logic                 polling_armed;

	// Local copy of the scoreboard state and registers
	bit               seen_map [MAX_PACKETS];
	int               seen_total = 0;
	int               top_seq = 0;
	int               floor_idx = 0;
	int               scan_pos = 0;
	bit               poll_armed = 1'b0;
	logic [CNT_W-1:0] cfg_count = CNT_W'(1);
	logic [LEN_W-1:0] cfg_last = LEN_W'(PAYLOAD_BYTES);

	result_t pending_results [$];
	int      nack_backlog [$];
	int      burst_left = 0;
	int      err_count = 0;
	int      result_count = 0;
	int      request_count = 0;
	int      taken_count = 0;
	int      nack_count = 0;
	int      config_writes = 0;
	int      cycle_count = 0;
	logic [9:0] ready_tick = '0;

	nack_receive_scoreboard dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.seq_num       (seq_num),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.accepted      (accepted),
		.write_offset  (write_offset),
		.write_length  (write_length),
		.nack_valid    (nack_valid),
		.nack_seq      (nack_seq),
		.all_received  (all_received),
		.polling_armed (polling_armed)
	);

	always #2 clk = ~clk;

	// Timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver stalls: rotates through always-ready, sparse, periodic and coin-flip windows
	always @(posedge clk) begin
		ready_tick <= ready_tick + 10'd1;
		case (ready_tick[9:8])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= ($urandom_range(0, 3) != 0);
			2'd2: out_ready <= (ready_tick[3:0] < 4'd11);
			default: out_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	task automatic flag_mismatch(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("MISMATCH %s", msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			flag_mismatch($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
				result_count, name, want, got));
	endtask

	// Expected result of one request; advances the local state
	function automatic result_t score_request(input logic req_op,
			input logic [SEQ_IN_W-1:0] req_seq);
		result_t r;
		int n;
		int s;
		int lim;
		int i;
		r = '0;
		n = (cfg_count > MAX_PACKETS) ? MAX_PACKETS : int'(cfg_count);
		s = int'(req_seq);
		if (req_op == OP_ARRIVAL) begin
			// new, in-range arrival sets its bit
			if (s < n && !seen_map[s]) begin
				seen_map[s] = 1'b1;
				seen_total++;
				if (s > top_seq)
					top_seq = s;
				r.accepted = 1'b1;
				r.write_offset = OFFS_W'(s * PAYLOAD_BYTES);
				r.write_length = (s == n - 1) ? cfg_last : LEN_W'(PAYLOAD_BYTES);
			end
			if (seen_total != n && top_seq * RATIO_DEN >= n * ARM_NUM)
				poll_armed = 1'b1;
		end else if (poll_armed && seen_total != n) begin
			// floor advance, bounded by lookahead
			lim = top_seq;
			if (top_seq * RATIO_DEN > n * EARLY_NUM)
				lim += (n * LOOK_NUM) / RATIO_DEN;
			while (floor_idx <= lim && floor_idx < n && seen_map[floor_idx])
				floor_idx++;
			// gap scan from the cursor
			i = scan_pos;
			while (i < n && seen_map[i])
				i++;
			if (i < n) begin
				r.nack_valid = 1'b1;
				r.nack_seq = SEQ_W'(i);
				scan_pos = (i == n - 1) ? floor_idx : i + 1;
			end else begin
				scan_pos = floor_idx;
			end
		end
		r.all_received = (seen_total == n);
		r.polling_armed = poll_armed;
		return r;
	endfunction

	// Result checker
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("result %0d arrived with nothing pending",
					result_count));
			end else begin
				want = pending_results.pop_front();
				compare_field("accepted", 32'(want.accepted), 32'(accepted));
				compare_field("write_offset", 32'(want.write_offset), 32'(write_offset));
				compare_field("write_length", 32'(want.write_length), 32'(write_length));
				compare_field("nack_valid", 32'(want.nack_valid), 32'(nack_valid));
				compare_field("nack_seq", 32'(want.nack_seq), 32'(nack_seq));
				compare_field("all_received", 32'(want.all_received), 32'(all_received));
				compare_field("polling_armed", 32'(want.polling_armed),
					32'(polling_armed));
			end
			result_count++;
		end
	end

	// One request, with burst/gap pacing on the sender side
	task automatic send_request(input logic req_op, input logic [SEQ_IN_W-1:0] req_seq);
		result_t want;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= req_op;
		seq_num <= req_seq;
		do @(posedge clk); while (!in_ready);
		want = score_request(req_op, req_seq);
		pending_results.push_back(want);
		request_count++;
		if (want.accepted)
			taken_count++;
		if (want.nack_valid) begin
			nack_count++;
			nack_backlog.push_back(int'(want.nack_seq));
		end
	endtask

	// Stop sending and let every pending result drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_PACKET_COUNT)
			cfg_count = data;
		else
			cfg_last = data[LEN_W-1:0];
		config_writes++;
	endtask

	task automatic set_transfer(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] last_bytes);
		wait_idle();
		write_reg(REG_PACKET_COUNT, count);
		write_reg(REG_LAST_BYTES, last_bytes);
	endtask

	// In-order stream with losses, NACK-driven resends, polls and some junk
	task automatic random_traffic(input int first_seq, input int n_items);
		int next_seq;
		int pick;
		int eff;
		int k;
		logic [SEQ_IN_W-1:0] s;
		eff = (cfg_count > MAX_PACKETS) ? MAX_PACKETS : int'(cfg_count);
		next_seq = first_seq;
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55 && next_seq >= eff)
				pick = 55;
			if (pick < 55) begin
				// roughly one packet in eight is lost
				if ($urandom_range(0, 7) == 0)
					next_seq++;
				send_request(OP_ARRIVAL, SEQ_IN_W'(next_seq));
				next_seq++;
			end else if (pick < 72) begin
				if (nack_backlog.size() > 0)
					send_request(OP_ARRIVAL, SEQ_IN_W'(nack_backlog.pop_front()));
				else
					send_request(OP_POLL, SEQ_IN_W'($urandom));
			end else if (pick < 82) begin
				if ($urandom_range(0, 1))
					s = SEQ_IN_W'($urandom);
				else
					s = SEQ_IN_W'($urandom_range(0, (eff > 0) ? eff - 1 : 0));
				send_request(OP_ARRIVAL, s);
			end else begin
				send_request(OP_POLL, SEQ_IN_W'($urandom));
			end
		end
	endtask

	// Zero packet count: nothing accepted, transfer reads complete
	task automatic test_empty_transfer();
		wait_idle();
		write_reg(REG_PACKET_COUNT, '0);
		send_request(OP_ARRIVAL, '0);
		send_request(OP_ARRIVAL, '1);
		send_request(OP_POLL, '0);
	endtask

	// One-packet transfer with the reset last length; out of range, new, duplicate
	task automatic test_single_packet();
		wait_idle();
		write_reg(REG_PACKET_COUNT, CFG_W'(1));
		send_request(OP_ARRIVAL, SEQ_IN_W'(1));
		send_request(OP_ARRIVAL, '0);
		send_request(OP_ARRIVAL, '0);
		send_request(OP_POLL, '1);
	endtask

	// Small transfer: arming, first NACKs, duplicates and junk, then random traffic
	task automatic test_small_transfer();
		set_transfer(CFG_W'(40), CFG_W'(1));
		send_request(OP_ARRIVAL, '0);
		send_request(OP_ARRIVAL, SEQ_IN_W'(39));
		send_request(OP_POLL, '1);
		send_request(OP_ARRIVAL, SEQ_IN_W'(1));
		send_request(OP_ARRIVAL, SEQ_IN_W'(39));
		send_request(OP_ARRIVAL, SEQ_IN_W'(40));
		send_request(OP_ARRIVAL, SEQ_IN_W'(16'h8000));
		send_request(OP_POLL, '0);
		send_request(OP_POLL, SEQ_IN_W'(16'h5A5A));
		random_traffic(2, 80);
	endtask

	// Last-packet length taken from the register, upper bits masked, and zero
	task automatic test_last_length();
		set_transfer(CFG_W'(41), '1);
		send_request(OP_ARRIVAL, SEQ_IN_W'(40));
		set_transfer(CFG_W'(42), '0);
		send_request(OP_ARRIVAL, SEQ_IN_W'(41));
		send_request(OP_POLL, '0);
	endtask

	// Growing transfers up to and past the bitmap size
	task automatic test_stream_phases();
		set_transfer(CFG_W'(300), CFG_W'(777));
		random_traffic(42, 200);
		set_transfer(CFG_W'(1000), CFG_W'(13'h1ABC));
		random_traffic(300, 150);
		set_transfer(CFG_W'(MAX_PACKETS), CFG_W'(PAYLOAD_BYTES));
		random_traffic(3000, 100);
		set_transfer('1, CFG_W'(1));
		random_traffic(4030, 80);
	endtask

	// Count shrunk below floor and cursor: scans find nothing
	task automatic test_shrunk_count();
		set_transfer(CFG_W'(20), CFG_W'(5));
		send_request(OP_POLL, '0);
		random_traffic(0, 30);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_transfer();
		test_single_packet();
		test_small_transfer();
		test_last_length();
		test_stream_phases();
		test_shrunk_count();

		wait_idle();
		repeat (END_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		$display("ran %0d requests over %0d register writes: %0d arrivals taken, %0d NACKs",
			request_count, config_writes, taken_count, nack_count);
		$display("checked %0d results, %0d mismatches", result_count, err_count);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
